FILE: hw/rtl/vcpt_pkg.sv
// Shared types and constants for the visual center PD tracker.
// Payload structs, configuration register map, stage bundles, fixed-point sizes.
`default_nettype none

package vcpt_pkg;

	localparam int FRAC_BITS = 8;
	localparam int GAIN_FRAC = 8;
	localparam int UP_SHIFT = (FRAC_BITS >= GAIN_FRAC) ? (FRAC_BITS - GAIN_FRAC) : 0;
	localparam int DN_SHIFT = (FRAC_BITS < GAIN_FRAC) ? (GAIN_FRAC - FRAC_BITS) : 0;
	localparam int HALF_LSB = (DN_SHIFT > 0) ? (1 << (DN_SHIFT - 1)) : 0;

	localparam int ERR_W = 18;
	localparam int DLT_W = 9;
	localparam int PROD_W = 34;
	localparam int DPROD_W = 25;
	localparam int TERM_W = 36 + UP_SHIFT;
	localparam int SUM_W = TERM_W + 1;
	localparam int TGT_W = $clog2(300 << FRAC_BITS) + 2;
	localparam int OUT_W = 17;

	localparam logic signed [TGT_W-1:0] Y_MAX = TGT_W'(250 << FRAC_BITS);
	localparam logic signed [TGT_W-1:0] Y_MIN = -Y_MAX;
	localparam logic signed [TGT_W-1:0] Z_MAX = TGT_W'(300 << FRAC_BITS);
	localparam logic signed [TGT_W-1:0] Z_MIN = TGT_W'(175 << FRAC_BITS);
	localparam logic signed [TGT_W-1:0] Z_RESET = TGT_W'(200 << FRAC_BITS);

	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_D       = 3'd1,
		REG_CENTER_X     = 3'd2,
		REG_CENTER_Y     = 3'd3,
		REG_DEAD_BAND    = 3'd4,
		REG_RELEASE_BAND = 3'd5,
		REG_DELTA_LIMIT  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_d;
		logic [9:0]  center_x;
		logic [9:0]  center_y;
		logic [7:0]  dead_band;
		logic [7:0]  release_band;
		logic [7:0]  delta_limit;
	} cfg_t;

	typedef struct packed {
		logic [15:0] blob_x;
		logic [15:0] blob_y;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] aim_y;
		logic [OUT_W-1:0]        aim_z;
		logic                    lock_flag;
		logic                    updated;
	} res_t;

	typedef struct packed {
		logic in_rel;
		logic in_db;
	} band_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] ex;
		logic signed [ERR_W-1:0] ey;
		logic signed [DLT_W-1:0] dax;
		logic signed [DLT_W-1:0] dbx;
		logic signed [DLT_W-1:0] day;
		logic signed [DLT_W-1:0] dby;
		band_t                   band;
	} delta_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] tax;
		logic signed [TERM_W-1:0] tbx;
		logic signed [TERM_W-1:0] tay;
		logic signed [TERM_W-1:0] tby;
		band_t                    band;
	} term_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vcpt_front.sv
// Error front end: center minus blob, lock band compares, clamped error changes.
// Uses vcpt_pkg. Change candidates cover a previous error of zero or the last raw error.
`default_nettype none

module vcpt_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            take,
	input  wire vcpt_pkg::item_t item,
	input  wire vcpt_pkg::cfg_t  cfg,
	output logic                 v_s2,
	output vcpt_pkg::delta_t     delta_s2
);

	localparam int EW = vcpt_pkg::ERR_W;
	localparam int DW = vcpt_pkg::DLT_W;

	logic                 v_s1;
	logic signed [EW-1:0] ex_s1, ey_s1;
	logic signed [EW-1:0] lastx_q, lasty_q;
	logic signed [EW-1:0] ex_in, ey_in;
	logic [EW-1:0]        absx, absy;
	vcpt_pkg::delta_t     delta_d;

	function automatic logic signed [DW-1:0] clamp_dlt(input logic signed [EW:0] v,
			input logic [7:0] lim);
		logic signed [EW:0] hi;
		hi = $signed({{(EW-7){1'b0}}, lim});
		if (v > hi)
			return DW'(hi);
		else if (v < -hi)
			return DW'(-hi);
		return DW'(v);
	endfunction

	assign ex_in = $signed({{(EW-10){1'b0}}, cfg.center_x}) - $signed({2'b00, item.blob_x});
	assign ey_in = $signed({{(EW-10){1'b0}}, cfg.center_y}) - $signed({2'b00, item.blob_y});

	always_comb begin
		absx = ex_s1[EW-1] ? EW'(-ex_s1) : ex_s1;
		absy = ey_s1[EW-1] ? EW'(-ey_s1) : ey_s1;
		delta_d.ex = ex_s1;
		delta_d.ey = ey_s1;
		delta_d.dax = clamp_dlt((EW+1)'(ex_s1), cfg.delta_limit);
		delta_d.day = clamp_dlt((EW+1)'(ey_s1), cfg.delta_limit);
		delta_d.dbx = clamp_dlt((EW+1)'(ex_s1) - (EW+1)'(lastx_q), cfg.delta_limit);
		delta_d.dby = clamp_dlt((EW+1)'(ey_s1) - (EW+1)'(lasty_q), cfg.delta_limit);
		delta_d.band.in_rel = (absx <= EW'(cfg.release_band)) &&
			(absy <= EW'(cfg.release_band));
		delta_d.band.in_db = (absx <= EW'(cfg.dead_band)) && (absy <= EW'(cfg.dead_band));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			lastx_q <= '0;
			lasty_q <= '0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			if (v_s1) begin
				lastx_q <= ex_s1;
				lasty_q <= ey_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s1 <= ex_in;
			ey_s1 <= ey_in;
			delta_s2 <= delta_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/vcpt_gain.sv
// Gain stages: error times gain_p, change candidates times gain_d, Q.8 rescale.
// Uses vcpt_pkg. Two registered stages, products then summed terms.
`default_nettype none

module vcpt_gain (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             v_s2,
	input  wire vcpt_pkg::delta_t delta_s2,
	input  wire vcpt_pkg::cfg_t   cfg,
	output logic                  v_s4,
	output vcpt_pkg::term_t       term_s4
);

	localparam int PW = vcpt_pkg::PROD_W;
	localparam int QW = vcpt_pkg::DPROD_W;
	localparam int TW = vcpt_pkg::TERM_W;

	typedef struct packed {
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic signed [QW-1:0] qax;
		logic signed [QW-1:0] qbx;
		logic signed [QW-1:0] qay;
		logic signed [QW-1:0] qby;
		vcpt_pkg::band_t      band;
	} prod_t;

	logic                 v_s3;
	prod_t                prod_s3, prod_d;
	vcpt_pkg::term_t      term_d;
	logic signed [PW-1:0] kp_w;
	logic signed [QW-1:0] kd_w;

	function automatic logic signed [TW-1:0] rescale(input logic signed [PW-1:0] p,
			input logic signed [QW-1:0] q);
		logic signed [TW-1:0] s;
		s = TW'(p) + TW'(q) + TW'(vcpt_pkg::HALF_LSB);
		return (s >>> vcpt_pkg::DN_SHIFT) <<< vcpt_pkg::UP_SHIFT;
	endfunction

	assign kp_w = $signed({{(PW-16){1'b0}}, cfg.gain_p});
	assign kd_w = $signed({{(QW-16){1'b0}}, cfg.gain_d});

	always_comb begin
		prod_d.px = PW'(delta_s2.ex) * kp_w;
		prod_d.py = PW'(delta_s2.ey) * kp_w;
		prod_d.qax = QW'(delta_s2.dax) * kd_w;
		prod_d.qbx = QW'(delta_s2.dbx) * kd_w;
		prod_d.qay = QW'(delta_s2.day) * kd_w;
		prod_d.qby = QW'(delta_s2.dby) * kd_w;
		prod_d.band = delta_s2.band;
		term_d.tax = rescale(prod_s3.px, prod_s3.qax);
		term_d.tbx = rescale(prod_s3.px, prod_s3.qbx);
		term_d.tay = rescale(prod_s3.py, prod_s3.qay);
		term_d.tby = rescale(prod_s3.py, prod_s3.qby);
		term_d.band = prod_s3.band;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= prod_d;
			term_s4 <= term_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/vcpt_update.sv
// Lock hysteresis, target accumulation with saturation, and the result register.
// Uses vcpt_pkg. Holds the tracker state that closes the per-item loop.
`default_nettype none

module vcpt_update (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            v_s4,
	input  wire vcpt_pkg::term_t term_s4,
	output logic                 res_valid,
	output vcpt_pkg::res_t       res_data
);

	localparam int GW = vcpt_pkg::TGT_W;
	localparam int SW = vcpt_pkg::SUM_W;
	localparam int TW = vcpt_pkg::TERM_W;
	localparam int OW = vcpt_pkg::OUT_W;
	localparam int XW = (GW > OW) ? GW : OW;

	logic                 locked_q, last_pd_q, res_valid_q;
	logic signed [GW-1:0] target_y_q, target_z_q;
	logic signed [GW-1:0] ny, nz;
	logic signed [TW-1:0] ty, tz;
	logic signed [SW-1:0] sy, sz;
	logic signed [XW-1:0] oy, oz;
	logic                 dead;
	vcpt_pkg::res_t       res_q;

	function automatic logic signed [GW-1:0] sat(input logic signed [SW-1:0] v,
			input logic signed [GW-1:0] lo, input logic signed [GW-1:0] hi);
		if (v < SW'(lo))
			return lo;
		else if (v > SW'(hi))
			return hi;
		return GW'(v);
	endfunction

	always_comb begin
		dead = (locked_q && term_s4.band.in_rel) || term_s4.band.in_db;
		ty = last_pd_q ? term_s4.tbx : term_s4.tax;
		tz = last_pd_q ? term_s4.tby : term_s4.tay;
		sy = SW'(target_y_q) + SW'(ty);
		sz = SW'(target_z_q) + SW'(tz);
		ny = dead ? target_y_q : sat(sy, vcpt_pkg::Y_MIN, vcpt_pkg::Y_MAX);
		nz = dead ? target_z_q : sat(sz, vcpt_pkg::Z_MIN, vcpt_pkg::Z_MAX);
		oy = XW'(ny);
		oz = XW'(nz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			locked_q <= 1'b0;
			last_pd_q <= 1'b0;
			target_y_q <= '0;
			target_z_q <= vcpt_pkg::Z_RESET;
		end else if (adv) begin
			res_valid_q <= v_s4;
			if (v_s4) begin
				locked_q <= dead;
				last_pd_q <= !dead;
				target_y_q <= ny;
				target_z_q <= nz;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.aim_y <= oy[OW-1:0];
			res_q.aim_z <= oz[OW-1:0];
			res_q.lock_flag <= dead;
			res_q.updated <= !dead;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/visual_center_pd_tracker.sv
// Visual center PD tracker top level: configuration registers, pipeline control, checks.
// Uses vcpt_pkg, vcpt_front, vcpt_gain and vcpt_update.
//
// One blob center in, one arm target out, one transaction per clock sustained while the result
// register is not stalled. An item passes through error, change clamp, gain multiply, term
// rescale, then the lock and target update that writes the result register. The pipeline
// advances as a whole whenever the result register is empty or being taken, so item_stall
// follows res_stall while a result waits. Lock, previous-error choice and the targets are
// resolved in the last stage, which lets a new item enter every cycle the pipeline advances.
// Write configuration only while no transaction is in flight; cfg_ready is always high.
`default_nettype none

module visual_center_pd_tracker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire vcpt_pkg::item_t                    item_data,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output vcpt_pkg::res_t                          res_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [vcpt_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [vcpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	vcpt_pkg::cfg_t   cfg_q;
	vcpt_pkg::delta_t delta_s2;
	vcpt_pkg::term_t  term_s4;
	logic             adv, v_s2, v_s4;

	assign adv = !res_valid || !res_stall;
	assign item_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p <= 16'd256;
			cfg_q.gain_d <= 16'd0;
			cfg_q.center_x <= 10'd160;
			cfg_q.center_y <= 10'd120;
			cfg_q.dead_band <= 8'd10;
			cfg_q.release_band <= 8'd16;
			cfg_q.delta_limit <= 8'd40;
		end else if (cfg_valid && cfg_ready) begin
			unique case (vcpt_pkg::reg_idx_t'(cfg_index))
				vcpt_pkg::REG_GAIN_P:       cfg_q.gain_p <= cfg_data;
				vcpt_pkg::REG_GAIN_D:       cfg_q.gain_d <= cfg_data;
				vcpt_pkg::REG_CENTER_X:     cfg_q.center_x <= cfg_data[9:0];
				vcpt_pkg::REG_CENTER_Y:     cfg_q.center_y <= cfg_data[9:0];
				vcpt_pkg::REG_DEAD_BAND:    cfg_q.dead_band <= cfg_data[7:0];
				vcpt_pkg::REG_RELEASE_BAND: cfg_q.release_band <= cfg_data[7:0];
				vcpt_pkg::REG_DELTA_LIMIT:  cfg_q.delta_limit <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	vcpt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.take     (item_valid),
		.item     (item_data),
		.cfg      (cfg_q),
		.v_s2     (v_s2),
		.delta_s2 (delta_s2)
	);

	vcpt_gain u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_s2     (v_s2),
		.delta_s2 (delta_s2),
		.cfg      (cfg_q),
		.v_s4     (v_s4),
		.term_s4  (term_s4)
	);

	vcpt_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.v_s4      (v_s4),
		.term_s4   (term_s4),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	a_lock_xor_update: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.updated != res_data.lock_flag))
		else $error("lock_flag and updated both set or both clear");

	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> item_stall)
		else $error("item taken while a stalled result blocks the pipeline");

	a_stall_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall) |-> !item_stall)
		else $error("input stalled while the result register drains");

endmodule

`default_nettype wire
